// ----- hw/rtl/segment_polyline_intersect_core_assert.svh -----
// Assertion macros for the segment/polyline intersection core.
`ifndef SEGMENT_POLYLINE_INTERSECT_CORE_ASSERT_SVH
`define SEGMENT_POLYLINE_INTERSECT_CORE_ASSERT_SVH
`ifndef SYNTH
// Implication checked at every clock edge outside reset.
`define SPI_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after its trigger.
`define SPI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SPI_ASSERT_IMP(label, clk, rst_n, pre, post)
`define SPI_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- hw/rtl/spi_pkg.sv -----
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types and constants of the segment/polyline intersection core.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_VERTICES = 65536;
    localparam int SEG_CAP      = (MAX_VERTICES - 1) < 65535 ? (MAX_VERTICES - 1) : 65535;
    localparam int VERT_EPS     = 7;
    localparam int CROSS_W      = 68;
    localparam int FCNT_W       = $clog2(FRAC_BITS + 2);

    typedef enum logic [1:0] {
        REG_QSX = 2'd0,
        REG_QSY = 2'd1,
        REG_QEX = 2'd2,
        REG_QEY = 2'd3
    } reg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture vertex, compute differences
        logic prod;    // compute products step
        logic sum;     // form cross sums
        logic norm;    // normalize signs
        logic div;     // one quotient bit
        logic lerp;    // multiply fraction by deltas
        logic fin;     // round and add
        logic commit;  // update previous vertex
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bbox_ok;
        logic unit_ok;
        logic div_done;
    } dp_stat_t;

endpackage

// ----- hw/rtl/spi_datapath.sv -----
// ----------------------------------------------------------------------------
// spi_datapath
// Differences, cross products, range tests, shift-subtract divider and lerp.
// ----------------------------------------------------------------------------
module spi_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic signed [31:0]     qsx,
    input  logic signed [31:0]     qsy,
    input  logic signed [31:0]     qex,
    input  logic signed [31:0]     qey,
    input  logic signed [31:0]     vx,
    input  logic signed [31:0]     vy,
    input  spi_pkg::dp_cmd_t       cmd,
    output spi_pkg::dp_stat_t      stat,
    output logic [16:0]            frac,
    output logic signed [31:0]     hx,
    output logic signed [31:0]     hy
);
    import spi_pkg::*;

    logic signed [32:0] px_reg, py_reg, cx_reg, cy_reg;
    logic signed [33:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, ex_reg, ey_reg;
    logic               bbox_reg, vq_reg, vb_reg, ovl_reg;
    logic signed [33:0] lo_reg;
    logic signed [CROSS_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [CROSS_W-1:0] num_reg, den_reg, na_reg, da_reg;
    logic               unit_reg;
    logic [CROSS_W-1:0] rem_reg;
    logic [FRAC_BITS:0] q_reg;
    logic [FCNT_W-1:0]  cnt_reg;
    logic [63:0]        mx_reg, my_reg;
    logic signed [32:0] sx_reg, sy_reg;
    logic               negx_reg, negy_reg;
    logic signed [31:0] hx_reg, hy_reg;

    logic signed [32:0] nx, ny, mnqx, mxqx, mnqy, mxqy, mnbx, mxbx, mnby, mxby;
    logic signed [33:0] ddxa, ddya, ddxb, ddyb;
    logic signed [33:0] ylo, yhi;
    logic [CROSS_W-1:0] rem_sh;
    logic [33:0]        adx, ady;

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        mag34 = v[33] ? 34'(-v) : 34'(v);
    endfunction

    always_comb
    begin
        nx   = 33'(vx);
        ny   = 33'(vy);
        mnqx = (qsx < qex) ? 33'(qsx) : 33'(qex);
        mxqx = (qsx < qex) ? 33'(qex) : 33'(qsx);
        mnqy = (qsy < qey) ? 33'(qsy) : 33'(qey);
        mxqy = (qsy < qey) ? 33'(qey) : 33'(qsy);
        mnbx = (px_reg < nx) ? px_reg : nx;
        mxbx = (px_reg < nx) ? nx : px_reg;
        mnby = (py_reg < ny) ? py_reg : ny;
        mxby = (py_reg < ny) ? ny : py_reg;
        ddxa = 34'(qex) - 34'(qsx);
        ddya = 34'(qey) - 34'(qsy);
        ddxb = 34'(nx) - 34'(px_reg);
        ddyb = 34'(ny) - 34'(py_reg);
        ylo  = (mnqy > mnby) ? 34'(mnqy) : 34'(mnby);
        yhi  = (mxqy < mxby) ? 34'(mxqy) : 34'(mxby);
        rem_sh = {rem_reg[CROSS_W-2:0], 1'b0};
        adx  = mag34(dxb_reg);
        ady  = mag34(dyb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg  <= '0;
            py_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                px_reg <= cx_reg;
                py_reg <= cy_reg;
            end
            if (cmd.norm)
                cnt_reg <= '0;
            else if (cmd.div)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg   <= nx;
            cy_reg   <= ny;
            dxa_reg  <= ddxa;
            dya_reg  <= ddya;
            dxb_reg  <= ddxb;
            dyb_reg  <= ddyb;
            ex_reg   <= 34'(px_reg) - 34'(qsx);
            ey_reg   <= 34'(py_reg) - 34'(qsy);
            bbox_reg <= !(mnbx > mxqx || mxbx < mnqx || mnby > mxqy || mxby < mnqy);
            vq_reg   <= mag34(ddxa) < 34'(VERT_EPS);
            vb_reg   <= mag34(ddxb) < 34'(VERT_EPS);
            ovl_reg  <= ylo < yhi;
            lo_reg   <= ylo;
            sx_reg   <= px_reg;
            sy_reg   <= py_reg;
        end
        if (cmd.prod)
        begin
            // cross product terms; one 34x34 multiply each, registered
            p0_reg <= CROSS_W'(dxa_reg * dyb_reg);
            p1_reg <= CROSS_W'(dya_reg * dxb_reg);
            p2_reg <= CROSS_W'(ex_reg * dya_reg);
            p3_reg <= CROSS_W'(ey_reg * dxa_reg);
            p4_reg <= CROSS_W'(ex_reg * dyb_reg);
            p5_reg <= CROSS_W'(ey_reg * dxb_reg);
        end
        if (cmd.sum)
        begin
            if (vq_reg)
            begin
                if (vb_reg)
                begin
                    num_reg <= CROSS_W'(lo_reg - 34'(sy_reg));
                    den_reg <= CROSS_W'(dyb_reg);
                end
                else
                begin
                    num_reg <= CROSS_W'(-ex_reg);
                    den_reg <= CROSS_W'(dxb_reg);
                end
                na_reg <= '0;
                da_reg <= 68'sd1;
            end
            else
            begin
                num_reg <= p2_reg - p3_reg;
                den_reg <= p0_reg - p1_reg;
                na_reg  <= p4_reg - p5_reg;
                da_reg  <= p0_reg - p1_reg;
            end
        end
        if (cmd.norm)
        begin
            logic signed [CROSS_W-1:0] n1, d1, n2, d2;
            n1 = den_reg[CROSS_W-1] ? -num_reg : num_reg;
            d1 = den_reg[CROSS_W-1] ? -den_reg : den_reg;
            n2 = da_reg[CROSS_W-1] ? -na_reg : na_reg;
            d2 = da_reg[CROSS_W-1] ? -da_reg : da_reg;
            unit_reg <= (den_reg != 0) && !n1[CROSS_W-1] && (n1 <= d1)
                     && (da_reg != 0) && !n2[CROSS_W-1] && (n2 <= d2)
                     && !(vq_reg && vb_reg && !ovl_reg);
            num_reg  <= n1;
            den_reg  <= d1;
            rem_reg  <= n1;
            q_reg    <= (n1 == d1) ? (FRAC_BITS+1)'(1) << FRAC_BITS : '0;
        end
        if (cmd.div && !q_reg[FRAC_BITS])
        begin
            // restoring division; last step is the rounding bit
            if (cnt_reg < FCNT_W'(FRAC_BITS))
            begin
                if (rem_sh >= den_reg)
                begin
                    rem_reg <= rem_sh - den_reg;
                    q_reg   <= {q_reg[FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[FRAC_BITS-1:0], 1'b0};
                end
            end
            else if (cnt_reg == FCNT_W'(FRAC_BITS) && rem_sh >= den_reg)
                q_reg <= q_reg + 1'b1;
        end
        if (cmd.lerp)
        begin
            mx_reg   <= 64'(q_reg) * 64'(adx);
            my_reg   <= 64'(q_reg) * 64'(ady);
            negx_reg <= dxb_reg[33];
            negy_reg <= dyb_reg[33];
        end
        if (cmd.fin)
        begin
            logic [63:0] rx, ry;
            rx = (mx_reg + (64'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
            ry = (my_reg + (64'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
            hx_reg <= 32'(negx_reg ? 64'(sx_reg) - rx : 64'(sx_reg) + rx);
            hy_reg <= 32'(negy_reg ? 64'(sy_reg) - ry : 64'(sy_reg) + ry);
        end
    end

    assign stat.bbox_ok  = bbox_reg;
    assign stat.unit_ok  = unit_reg;
    assign stat.div_done = cnt_reg == FCNT_W'(FRAC_BITS);
    assign frac = q_reg;
    assign hx   = hx_reg;
    assign hy   = hy_reg;

endmodule

// ----- hw/rtl/spi_ctrl.sv -----
// ----------------------------------------------------------------------------
// spi_ctrl
// Sequencer: vertex transfer, test steps, division loop, result output.
// ----------------------------------------------------------------------------
`include "segment_polyline_intersect_core_assert.svh"
module spi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_take,
    input  logic               first,
    input  logic               out_take,
    input  spi_pkg::dp_stat_t  stat,
    output spi_pkg::dp_cmd_t   cmd,
    output logic               busy,
    output logic               out_valid,
    output logic [15:0]        seg_idx
);
    import spi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_PROD, S_SUM, S_NORM, S_DECIDE, S_DIV, S_LERP, S_FIN, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic        pv_reg;
    logic [15:0] cnt_reg, idx_reg;
    logic        test_reg;
    logic        ov_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_take) begin cmd.load = 1'b1; state_next = S_CHK; end
            S_CHK:    state_next = (test_reg && stat.bbox_ok) ? S_PROD : S_IDLE;
            S_PROD:   begin cmd.prod = 1'b1; state_next = S_SUM; end
            S_SUM:    begin cmd.sum = 1'b1; state_next = S_NORM; end
            S_NORM:   begin cmd.norm = 1'b1; state_next = S_DECIDE; end
            S_DECIDE: state_next = stat.unit_ok ? S_DIV : S_IDLE;
            S_DIV:    begin cmd.div = 1'b1; if (stat.div_done) state_next = S_LERP; end
            S_LERP:   begin cmd.lerp = 1'b1; state_next = S_FIN; end
            S_FIN:    begin cmd.fin = 1'b1; state_next = S_OUT; end
            S_OUT:    if (out_take) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        cmd.commit = state_reg == S_CHK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pv_reg    <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            test_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= state_next == S_OUT;
            if (in_take)
            begin
                pv_reg <= 1'b1;
                if (first || !pv_reg)
                begin
                    cnt_reg  <= '0;
                    test_reg <= 1'b0;
                end
                else if (32'(cnt_reg) < 32'(SEG_CAP))
                begin
                    idx_reg  <= cnt_reg;
                    cnt_reg  <= cnt_reg + 1'b1;
                    test_reg <= 1'b1;
                end
                else
                    test_reg <= 1'b0;
            end
        end
    end

    assign busy      = state_reg != S_IDLE;
    assign out_valid = ov_reg;
    assign seg_idx   = idx_reg;

    `SPI_ASSERT_IMP(a_take_idle, clk, rst_n, in_take, state_reg == S_IDLE)
    `SPI_ASSERT_IMP(a_out_state, clk, rst_n, out_valid, state_reg == S_OUT)
    `SPI_ASSERT_NEXT(a_out_release, clk, rst_n, out_valid && out_take, !out_valid)
    `SPI_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, 32'(cnt_reg) <= 32'(SEG_CAP))

endmodule

// ----- hw/rtl/segment_polyline_intersect_core.sv -----
// ----------------------------------------------------------------------------
// segment_polyline_intersect_core
// Tests each polyline segment against a configured query segment.
// ----------------------------------------------------------------------------
//  channel | signals                                          | handshake
//  in      | vertex_x, vertex_y, first_vertex                 | in_valid/in_stall
//  out     | segment_index, fraction, hit_x, hit_y            | out_valid/out_stall
//  cfg     | cfg_we, cfg_index, cfg_data                      | write enable
// A vertex that is not tested or misses the bounding box returns to idle after the
// check; one with a parameter outside [0,1] returns after the decide step; a hit
// goes on through the divider, lerp and rounding to the result output.
// The 17-step shift-subtract divider sits on the hit path.
// One vertex is in flight at a time; in_stall is high while busy.
// A result holds on the outputs until out_stall is low.
// Reset clears query registers, previous vertex and the segment counter.
module segment_polyline_intersect_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] vertex_x,
    input  logic signed [31:0] vertex_y,
    input  logic               first_vertex,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        segment_index,
    output logic [16:0]        fraction,
    output logic signed [31:0] hit_x,
    output logic signed [31:0] hit_y
);
    import spi_pkg::*;

    logic signed [31:0] qsx_reg, qsy_reg, qex_reg, qey_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     busy, in_take, out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsx_reg <= '0;
            qsy_reg <= '0;
            qex_reg <= '0;
            qey_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_QSX: qsx_reg <= cfg_data;
                REG_QSY: qsy_reg <= cfg_data;
                REG_QEX: qex_reg <= cfg_data;
                REG_QEY: qey_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = busy;
    assign in_take  = in_valid && !busy;
    assign out_take = out_valid && !out_stall;

    spi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .first     (first_vertex),
        .out_take  (out_take),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid),
        .seg_idx   (segment_index)
    );

    spi_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .qsx   (qsx_reg),
        .qsy   (qsy_reg),
        .qex   (qex_reg),
        .qey   (qey_reg),
        .vx    (vertex_x),
        .vy    (vertex_y),
        .cmd   (cmd),
        .stat  (stat),
        .frac  (fraction),
        .hx    (hit_x),
        .hy    (hit_y)
    );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams polylines through segment_polyline_intersect_core under several
// query segments and checks every hit transfer against an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import spi_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int     RANDOM_ITEMS = 1400;

    typedef struct {
        logic [15:0] seg;
        logic [16:0] frac;
        logic [31:0] x;
        logic [31:0] y;
    } hit_t;

    class hit_scoreboard;
        longint qsx, qsy, qex, qey;
        longint prev_x, prev_y;
        bit     prev_ok;
        int     seg_count;
        hit_t   pending[$];
        int     errors;

        function new();
            qsx = 0; qsy = 0; qex = 0; qey = 0;
            prev_x = 0; prev_y = 0; prev_ok = 0; seg_count = 0; errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] d);
            longint v;
            v = longint'(signed'(d));
            case (idx)
                REG_QSX: qsx = v;
                REG_QSY: qsy = v;
                REG_QEX: qex = v;
                REG_QEY: qey = v;
            endcase
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint mn(longint a, longint b);
            return a < b ? a : b;
        endfunction

        function longint mx(longint a, longint b);
            return a > b ? a : b;
        endfunction

        // magnitude product kept to 64 bits, sign applied in 128
        function logic signed [127:0] wmul(longint a, longint b);
            longint unsigned m;
            logic signed [127:0] r;
            m = mag(a) * mag(b);
            r = {64'd0, m};
            return ((a < 0) != (b < 0)) ? -r : r;
        endfunction

        function bit in_unit(inout logic signed [127:0] num, inout logic signed [127:0] den);
            if (den == 0) return 0;
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            if (num < 0) return 0;
            return num <= den;
        endfunction

        function longint unsigned ratio(logic signed [127:0] num, logic signed [127:0] den);
            longint unsigned q;
            q = 0;
            if (num == den) return longint'(1) << FRAC_BITS;
            for (int i = 0; i < FRAC_BITS; i++) begin
                num = num <<< 1;
                q = q << 1;
                if (num >= den) begin
                    num = num - den;
                    q = q | 1;
                end
            end
            num = num <<< 1;
            if (num >= den) q++;
            return q;
        endfunction

        function logic [31:0] lerp(longint start, longint delta, longint unsigned frac);
            longint unsigned m, q;
            longint off;
            m = frac * mag(delta);
            q = (m + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            off = delta < 0 ? -longint'(q) : longint'(q);
            return 32'(start + off);
        endfunction

        function bit crosses(longint x0b, longint y0b, longint x1b, longint y1b,
                             output longint unsigned frac);
            longint dxa, dya, dxb, dyb, lo, hi;
            logic signed [127:0] num, den, na, da;
            frac = 0;
            dxa = qex - qsx; dya = qey - qsy;
            dxb = x1b - x0b; dyb = y1b - y0b;
            if (mn(x0b, x1b) > mx(qsx, qex) || mx(x0b, x1b) < mn(qsx, qex) ||
                mn(y0b, y1b) > mx(qsy, qey) || mx(y0b, y1b) < mn(qsy, qey))
                return 0;
            if (mag(dxa) < VERT_EPS) begin
                if (mag(dxb) < VERT_EPS) begin
                    lo = mx(mn(qsy, qey), mn(y0b, y1b));
                    hi = mn(mx(qsy, qey), mx(y0b, y1b));
                    if (!(lo < hi)) return 0;
                    num = lo - y0b;
                    den = dyb;
                end else begin
                    num = qsx - x0b;
                    den = dxb;
                end
                if (!in_unit(num, den)) return 0;
            end else begin
                den = wmul(dxa, dyb) - wmul(dya, dxb);
                num = wmul(x0b - qsx, dya) - wmul(y0b - qsy, dxa);
                na  = wmul(x0b - qsx, dyb) - wmul(y0b - qsy, dxb);
                da  = den;
                if (!in_unit(num, den)) return 0;
                if (!in_unit(na, da)) return 0;
            end
            frac = ratio(num, den);
            return 1;
        endfunction

        function void note(logic [31:0] vx, logic [31:0] vy, bit first);
            longint x, y;
            longint unsigned frac;
            hit_t h;
            x = longint'(signed'(vx));
            y = longint'(signed'(vy));
            if (first || !prev_ok) begin
                seg_count = 0;
            end else if (seg_count < SEG_CAP) begin
                if (crosses(prev_x, prev_y, x, y, frac)) begin
                    h.seg  = 16'(seg_count);
                    h.frac = 17'(frac);
                    h.x    = lerp(prev_x, x - prev_x, frac);
                    h.y    = lerp(prev_y, y - prev_y, frac);
                    pending = {pending, h};
                end
                seg_count++;
            end
            prev_x = x;
            prev_y = y;
            prev_ok = 1;
        endfunction

        function void check(hit_t got);
            hit_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected hit seg=%0d frac=%h x=%h y=%h",
                         $time, got.seg, got.frac, got.x, got.y);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.seg !== want.seg) begin
                $display("%0t: segment_index expected %0d actual %0d", $time, want.seg, got.seg);
                errors++;
            end
            if (got.frac !== want.frac) begin
                $display("%0t: fraction expected %h actual %h", $time, want.frac, got.frac);
                errors++;
            end
            if (got.x !== want.x) begin
                $display("%0t: hit_x expected %h actual %h", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: hit_y expected %h actual %h", $time, want.y, got.y);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    reg_idx_t           cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               first_vertex;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        segment_index;
    logic [16:0]        fraction;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;

    hit_scoreboard sb = new();
    bit     quiet;
    int     stall_left;
    longint cycles;
    longint q_sx, q_sy, q_ex, q_ey;

    segment_polyline_intersect_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .first_vertex  (first_vertex),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .segment_index (segment_index),
        .fraction      (fraction),
        .hit_x         (hit_x),
        .hit_y         (hit_y)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // receiver side: stall draw per transfer, plus result checking
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check('{segment_index, fraction, hit_x, hit_y});
            stall_left = quiet ? 0 : $urandom_range(0, 12);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send(logic [31:0] x, logic [31:0] y, bit first);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        vertex_x     <= x;
        vertex_y     <= y;
        first_vertex <= first;
        do
            @(posedge clk);
        while (in_stall);
        sb.note(x, y, first);
    endtask

    // drain all results, then cover a miss still in progress
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_query(longint sx, longint sy, longint ex, longint ey);
        logic [31:0] vals[4];
        reg_idx_t    idx[4];
        vals = '{32'(sx), 32'(sy), 32'(ex), 32'(ey)};
        idx  = '{REG_QSX, REG_QSY, REG_QEX, REG_QEY};
        wait_idle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
        q_sx = sx; q_sy = sy; q_ex = ex; q_ey = ey;
    endtask

    function automatic longint near(longint c, int spread);
        return c + longint'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic longint rand_coord(longint a, longint b);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return longint'(signed'(32'($urandom())));
        if (r == 1) return a;
        return near((a + b) / 2, 8 << 16);
    endfunction

    initial
    begin
        longint px, nx, ny;
        int     sent;
        int     pick;
        rst_n = 0; cfg_we = 0; cfg_index = REG_QSX; cfg_data = 0;
        in_valid = 0; vertex_x = 0; vertex_y = 0; first_vertex = 0;
        out_stall = 0; stall_left = 0; cycles = 0; quiet = 0;
        q_sx = 0; q_sy = 0; q_ex = 0; q_ey = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no previous vertex after reset; zero-length query at origin
        send(32'h0001_0000, 32'h0001_0000, 1'b0);
        send(32'hFFFF_0000, 32'hFFFF_0000, 1'b0);
        // general case: crossing, parallel, endpoints
        write_query(0, 0, 4 << 16, 4 << 16);
        send(0, 32'(4 << 16), 1'b1);
        send(32'(4 << 16), 0, 1'b0);
        send(32'(5 << 16), 32'(1 << 16), 1'b0);
        send(32'(4 << 16), 32'(4 << 16), 1'b0);
        send(32'(2 << 16), 32'(2 << 16), 1'b0);
        send(0, 32'(1 << 16), 1'b0);
        // vertical query against sloped and vertical segments
        write_query(2 << 16, -(4 << 16), (2 << 16) + 3, 4 << 16);
        send(0, 0, 1'b1);
        send(32'(5 << 16), 32'(1 << 16), 1'b0);
        send(32'((2 << 16) + 5), 32'(-(6 << 16)), 1'b1);
        send(32'((2 << 16) + 2), 32'(2 << 16), 1'b0);
        send(32'(2 << 16), 32'(4 << 16), 1'b0);
        send(32'(2 << 16), 32'(9 << 16), 1'b0);
        // extremes
        write_query(-2147483648, -2147483648, 2147483647, 2147483647);
        send(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send(32'h8000_0000, 32'h8000_0000, 1'b0);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);

        // short run back to back
        write_query(0, 0, 1 << 16, 1 << 16);
        quiet = 1;
        send(32'h4000_0000, 32'h4000_0000, 1'b1);
        send(32'h0000_8000, 32'h0000_8000, 1'b0);
        send(32'h0001_0000, 0, 1'b0);
        send(0, 32'h0001_0000, 1'b1);
        send(32'h0001_0000, 0, 1'b0);
        quiet = 0;

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                write_query(rand_coord(0, 0), rand_coord(0, 0),
                            rand_coord(0, 0), rand_coord(0, 0));
            else if (pick == 1)
            begin
                nx = near(0, 4 << 16);
                write_query(nx, near(0, 8 << 16), nx + $urandom_range(0, 6) - 3,
                            near(0, 8 << 16));
            end
            else
                write_query(near(0, 8 << 16), near(0, 8 << 16),
                            near(0, 8 << 16), near(0, 8 << 16));
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 100; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    nx = longint'(signed'(32'($urandom())));
                    ny = longint'(signed'(32'($urandom())));
                end
                else if (pick <= 2)
                begin
                    // vertical-ish segment, often on the query line
                    nx = ($urandom_range(0, 1) ? q_sx : px) + $urandom_range(0, 12) - 6;
                    ny = rand_coord(q_sy, q_ey);
                end
                else
                begin
                    nx = rand_coord(q_sx, q_ex);
                    ny = rand_coord(q_sy, q_ey);
                end
                send(32'(nx), 32'(ny), $urandom_range(0, 19) == 0 || i == 0);
                px = nx;
                sent++;
            end
        end

        wait_idle();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
